// ===== rtl/lcd_scanline_mode_timer_top_macros.svh =====
// assertion macros for the lcd scanline mode timer
// no dependencies; taken in by files that carry concurrent checks
`ifndef LCD_SCANLINE_MODE_TIMER_TOP_MACROS_SVH
`define LCD_SCANLINE_MODE_TIMER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define LSMT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LSMT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LSMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LSMT_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define LSMT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define LSMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/lsmt_pkg.sv =====
// types and fixed constants of the lcd scanline mode timer
// no dependencies; used by the channel interfaces and the top level
package lsmt_pkg;

   localparam int CYCLES_W = 8;
   localparam int CNT_W    = 10;
   localparam int LINE_W   = 8;
   localparam int MODE_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int IRQ_EN_W   = 4;

   localparam int OAM_SPAN      = 80;
   localparam int TRANSFER_SPAN = 172;

   typedef enum logic [MODE_W-1:0] {
      MODE_HBLANK   = 2'd0,
      MODE_VBLANK   = 2'd1,
      MODE_OAM      = 2'd2,
      MODE_TRANSFER = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LCD_ENABLE   = 2'd0,
      CSR_LINE_COMPARE = 2'd1,
      CSR_IRQ_ENABLES  = 2'd2
   } csr_index_type;

   // bit positions in the status interrupt enable register
   localparam int IRQ_EN_HBLANK = 0;
   localparam int IRQ_EN_VBLANK = 1;
   localparam int IRQ_EN_OAM    = 2;
   localparam int IRQ_EN_COIN   = 3;

endpackage

// ===== rtl/lsmt_if.sv =====
// valid/ready channel interfaces of the lcd scanline mode timer
// depends on lsmt_pkg for the field widths
interface lsmt_req_if;
   logic                          valid;
   logic                          ready;
   logic [lsmt_pkg::CYCLES_W-1:0] elapsed_cycles;

   modport source (output valid, output elapsed_cycles, input ready);
   modport sink (input valid, input elapsed_cycles, output ready);
endinterface

interface lsmt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lsmt_pkg::MODE_W-1:0] mode_now;
   logic                        coincidence;
   logic [lsmt_pkg::LINE_W-1:0] line_now;
   logic                        stat_irq;
   logic                        vblank_irq;
   logic                        draw_request;

   modport source (output valid, output mode_now, output coincidence, output line_now,
                   output stat_irq, output vblank_irq, output draw_request, input ready);
   modport sink (input valid, input mode_now, input coincidence, input line_now,
                 input stat_irq, input vblank_irq, input draw_request, output ready);
endinterface

interface lsmt_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lsmt_pkg::CSR_IDX_W-1:0]  index;
   logic [lsmt_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lcd_scanline_mode_timer_top.sv =====
// lcd scanline mode timer: a word accepted is held in the input register, and when it
// advances, its result word is written into the output register
// throughput one word per cycle while the response side is not stalled; the line step is
// a single compare and subtract between the input register and the result register
// reset (synchronous): pipeline empty, counter, line, mode and coincidence zero,
// display enabled, compare value and interrupt enables zero
module lcd_scanline_mode_timer_top #(
   parameter int LINE_CYCLES   = 456,
   parameter int VISIBLE_LINES = 144,
   parameter int LAST_LINE     = 153
) (
   input logic        clock,
   input logic        reset,
   lsmt_req_if.sink   req_if,
   lsmt_rsp_if.source rsp_if,
   lsmt_csr_if.sink   csr_if
);

`include "lcd_scanline_mode_timer_top_macros.svh"

   localparam logic [lsmt_pkg::CNT_W-1:0] LINE_RELOAD = LINE_CYCLES[lsmt_pkg::CNT_W-1:0];
   localparam logic [lsmt_pkg::CNT_W-1:0] OAM_BOUND =
      LINE_RELOAD - lsmt_pkg::CNT_W'(lsmt_pkg::OAM_SPAN);
   localparam logic [lsmt_pkg::CNT_W-1:0] XFER_BOUND =
      OAM_BOUND - lsmt_pkg::CNT_W'(lsmt_pkg::TRANSFER_SPAN);
   localparam logic [lsmt_pkg::LINE_W-1:0] VISIBLE_L = VISIBLE_LINES[lsmt_pkg::LINE_W-1:0];
   localparam logic [lsmt_pkg::LINE_W-1:0] LAST_L    = LAST_LINE[lsmt_pkg::LINE_W-1:0];

   // configuration
   logic                            lcd_en_ff;
   logic [lsmt_pkg::LINE_W-1:0]     line_cmp_ff;
   logic [lsmt_pkg::IRQ_EN_W-1:0]   irq_en_ff;

   // input register
   logic                            in_valid_ff;
   logic                            in_valid_in;
   logic [lsmt_pkg::CYCLES_W-1:0]   in_cycles_ff;

   // timing state
   logic [lsmt_pkg::CNT_W-1:0]      counter_ff, counter_in;
   logic [lsmt_pkg::LINE_W-1:0]     line_ff, line_in;
   lsmt_pkg::mode_type              mode_ff, mode_in;
   logic                            coin_ff, coin_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   lsmt_pkg::mode_type              rsp_mode_ff, rsp_mode_in;
   logic                            rsp_coin_ff, rsp_coin_in;
   logic [lsmt_pkg::LINE_W-1:0]     rsp_line_ff, rsp_line_in;
   logic                            rsp_stat_ff, rsp_stat_in;
   logic                            rsp_vblank_ff, rsp_vblank_in;
   logic                            rsp_draw_ff, rsp_draw_in;

   logic                            advance;
   logic                            req_take;
   logic                            mode_req;
   logic                            line_match;
   logic                            expired;
   logic [lsmt_pkg::LINE_W-1:0]     line_inc;
   lsmt_pkg::mode_type              mode_calc;

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || advance;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.mode_now     = rsp_mode_ff;
   assign rsp_if.coincidence  = rsp_coin_ff;
   assign rsp_if.line_now     = rsp_line_ff;
   assign rsp_if.stat_irq     = rsp_stat_ff;
   assign rsp_if.vblank_irq   = rsp_vblank_ff;
   assign rsp_if.draw_request = rsp_draw_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // mode from the line and counter as they stand before this word
   always_comb begin
      mode_calc = lsmt_pkg::MODE_HBLANK;
      mode_req  = irq_en_ff[lsmt_pkg::IRQ_EN_HBLANK];
      if (line_ff >= VISIBLE_L) begin
         mode_calc = lsmt_pkg::MODE_VBLANK;
         mode_req  = irq_en_ff[lsmt_pkg::IRQ_EN_VBLANK];
      end else if (counter_ff >= OAM_BOUND) begin
         mode_calc = lsmt_pkg::MODE_OAM;
         mode_req  = irq_en_ff[lsmt_pkg::IRQ_EN_OAM];
      end else if (counter_ff >= XFER_BOUND) begin
         mode_calc = lsmt_pkg::MODE_TRANSFER;
         mode_req  = 1'b0;
      end
   end

   assign line_match = (line_cmp_ff == line_ff);
   assign expired    = (counter_ff <= {{(lsmt_pkg::CNT_W - lsmt_pkg::CYCLES_W){1'b0}},
                                       in_cycles_ff});
   assign line_inc   = line_ff + 1'b1;

   always_comb begin
      counter_in    = counter_ff;
      line_in       = line_ff;
      mode_in       = mode_ff;
      coin_in       = coin_ff;
      rsp_mode_in   = rsp_mode_ff;
      rsp_coin_in   = rsp_coin_ff;
      rsp_line_in   = rsp_line_ff;
      rsp_stat_in   = rsp_stat_ff;
      rsp_vblank_in = rsp_vblank_ff;
      rsp_draw_in   = rsp_draw_ff;
      if (advance) begin
         if (!lcd_en_ff) begin
            // display off holds the timer in vblank at line zero
            counter_in    = LINE_RELOAD;
            line_in       = '0;
            mode_in       = lsmt_pkg::MODE_VBLANK;
            rsp_mode_in   = lsmt_pkg::MODE_VBLANK;
            rsp_coin_in   = coin_ff;
            rsp_line_in   = '0;
            rsp_stat_in   = 1'b0;
            rsp_vblank_in = 1'b0;
            rsp_draw_in   = 1'b0;
         end else begin
            mode_in       = mode_calc;
            coin_in       = line_match;
            rsp_mode_in   = mode_calc;
            rsp_coin_in   = line_match;
            rsp_stat_in   = (mode_req && (mode_calc != mode_ff)) ||
                            (line_match && irq_en_ff[lsmt_pkg::IRQ_EN_COIN]);
            rsp_vblank_in = 1'b0;
            rsp_draw_in   = 1'b0;
            if (expired) begin
               counter_in = LINE_RELOAD;
               line_in    = line_inc;
               if (line_inc == VISIBLE_L) begin
                  rsp_vblank_in = 1'b1;
               end else if (line_inc > LAST_L) begin
                  line_in = '0;
               end else if (line_inc < VISIBLE_L) begin
                  rsp_draw_in = 1'b1;
               end
            end else begin
               counter_in = counter_ff -
                            {{(lsmt_pkg::CNT_W - lsmt_pkg::CYCLES_W){1'b0}}, in_cycles_ff};
            end
            rsp_line_in = line_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_en_ff    <= 1'b1;
         line_cmp_ff  <= '0;
         irq_en_ff    <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         counter_ff   <= '0;
         line_ff      <= '0;
         mode_ff      <= lsmt_pkg::MODE_HBLANK;
         coin_ff      <= 1'b0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_if.index)
               lsmt_pkg::CSR_LCD_ENABLE:   lcd_en_ff   <= csr_if.data[0];
               lsmt_pkg::CSR_LINE_COMPARE: line_cmp_ff <= csr_if.data[lsmt_pkg::LINE_W-1:0];
               lsmt_pkg::CSR_IRQ_ENABLES:  irq_en_ff   <= csr_if.data[lsmt_pkg::IRQ_EN_W-1:0];
               default: ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         counter_ff   <= counter_in;
         line_ff      <= line_in;
         mode_ff      <= mode_in;
         coin_ff      <= coin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cycles_ff <= req_if.elapsed_cycles;
      end
      rsp_mode_ff   <= rsp_mode_in;
      rsp_coin_ff   <= rsp_coin_in;
      rsp_line_ff   <= rsp_line_in;
      rsp_stat_ff   <= rsp_stat_in;
      rsp_vblank_ff <= rsp_vblank_in;
      rsp_draw_ff   <= rsp_draw_in;
   end

   `LSMT_ASSERT_ALWAYS(a_counter_range, clock, reset, counter_ff <= LINE_RELOAD, "counter above reload")
   `LSMT_ASSERT_ALWAYS(a_line_range, clock, reset, (line_ff <= LAST_L) || (line_ff == VISIBLE_L), "line out of range")
   `LSMT_ASSERT_IMPLIES(a_vblank_line, clock, reset, rsp_valid_ff && rsp_vblank_ff, (rsp_line_ff == VISIBLE_L) && !rsp_draw_ff, "vblank irq off line")
   `LSMT_ASSERT_IMPLIES(a_draw_visible, clock, reset, rsp_valid_ff && rsp_draw_ff, rsp_line_ff < VISIBLE_L, "draw of invisible line")
   `LSMT_ASSERT_NEXT(a_display_off, clock, reset, advance && !lcd_en_ff, (line_ff == '0) && (mode_ff == lsmt_pkg::MODE_VBLANK) && (counter_ff == LINE_RELOAD), "display off not held")

endmodule
